// ===== rtl/cubic_bezier_flattener_unit_macros.svh =====
`ifndef CUBIC_BEZIER_FLATTENER_UNIT_MACROS_SVH
`define CUBIC_BEZIER_FLATTENER_UNIT_MACROS_SVH

// All checks sample on i_clk; the first two stay quiet while i_rst_n is low.
`define CBF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define CBF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Checks what reset leaves behind, so it is not disabled by reset.
`define CBF_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) else $error(msg);

`endif

// ===== rtl/cbf_pkg.sv =====
package cbf_pkg;

    // Coordinate format
    localparam int COORD_W      = 24;
    localparam int FRAC_BITS    = 8;

    // Register widths
    localparam int SEG_W        = 6;
    localparam int FRAME_W      = 14;
    localparam int MAX_SEGMENTS = 63;

    // Datapath widths
    localparam int PT_W         = COORD_W + 1;     // biased, unsigned pixel-space point
    localparam int WGT_W        = 3 * SEG_W;       // Bernstein weight and n^3
    localparam int PROD_W       = PT_W + WGT_W;    // weighted sum
    localparam int QUO_W        = PT_W;            // quotient of the rounding divide

    // Divider: QUO_W must be a multiple of DIV_BITS
    localparam int DIV_BITS     = 5;
    localparam int DIV_STAGES   = QUO_W / DIV_BITS;

    // APB register file
    localparam int APB_DW       = 32;
    localparam int ADDR_W       = 4;
    localparam int REG_IDX_W    = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_SEG_COUNT    = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = REG_IDX_W'(2);

    localparam logic [SEG_W-1:0]   SEG_COUNT_RESET = SEG_W'(16);
    localparam logic [FRAME_W-1:0] FRAME_RESET     = FRAME_W'(1024);

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] ctrl1_x;
        logic signed [COORD_W-1:0] ctrl1_y;
        logic signed [COORD_W-1:0] ctrl2_x;
        logic signed [COORD_W-1:0] ctrl2_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic                      first_curve;
    } t_curve_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_point;
    } t_point_item;

endpackage

// ===== rtl/cubic_bezier_flattener_unit.sv =====
// Cubic Bezier flattener: one curve in, segment_count points out (plus the start point
// when first_curve is set), one point per cycle on the output channel while the sink
// accepts. The next curve is taken in the cycle the last point of the current one
// leaves the point sequencer.
// Reset (i_rst_n low, synchronous) empties the pipeline and restores the registers.
module cubic_bezier_flattener_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // curve input channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  cbf_pkg::t_curve_item           i_data,
    // point output channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output cbf_pkg::t_point_item           o_data,
    // APB register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cbf_pkg::ADDR_W-1:0]     paddr,
    input  logic [cbf_pkg::APB_DW-1:0]     pwdata,
    output logic [cbf_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);
    import cbf_pkg::*;

    // Four control points of one curve, already moved to pixel space and biased by
    // 2^(COORD_W-1) so every coordinate is non-negative. The bias passes through the
    // weighted average unchanged (weights sum to n^3) and is removed at the output.
    typedef struct packed {
        logic [3:0][PT_W-1:0] x;
        logic [3:0][PT_W-1:0] y;
    } t_curve_pts;

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [SEG_W-1:0]     r_seg_count;
    logic [FRAME_W-1:0]   r_frame_w;
    logic [FRAME_W-1:0]   r_frame_h;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= SEG_COUNT_RESET;
            r_frame_w   <= FRAME_RESET;
            r_frame_h   <= FRAME_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SEG_COUNT:    r_seg_count <= pwdata[SEG_W-1:0];
                REG_FRAME_WIDTH:  r_frame_w   <= pwdata[FRAME_W-1:0];
                REG_FRAME_HEIGHT: r_frame_h   <= pwdata[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_SEG_COUNT:    prdata = APB_DW'(r_seg_count);
            REG_FRAME_WIDTH:  prdata = APB_DW'(r_frame_w);
            REG_FRAME_HEIGHT: prdata = APB_DW'(r_frame_h);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline enable: the whole pipe moves unless the output register holds a
    // point that the sink does not take. Bubbles ride along as invalid stages.
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic pipe_en;

    assign pipe_en = !r_out_valid || i_ready;

    // Pixel-space offset is dim/2 with FRAC_BITS fraction bits, i.e. dim << (FRAC_BITS-1).
    // Flipping the sign bit of the coordinate adds the 2^(COORD_W-1) bias.
    function automatic logic [PT_W-1:0] to_biased(logic [COORD_W-1:0] c,
                                                   logic [FRAME_W-1:0] dim);
        logic [PT_W-1:0] half;
        half = PT_W'(dim) << (FRAC_BITS - 1);
        return {1'b0, ~c[COORD_W-1], c[COORD_W-2:0]} + half;
    endfunction

    // ------------------------------------------------------------------
    // Point sequencer: holds the current curve and steps i from 0 or 1 up to n.
    // i = 0 gives weights (n^3,0,0,0), which reproduces the start point exactly.
    // ------------------------------------------------------------------
    logic             r_busy;
    logic [SEG_W-1:0] r_n;
    logic [SEG_W-1:0] r_i;
    t_curve_pts       r_pts;
    t_curve_pts       n_pts;
    logic [SEG_W-1:0] n_seg;
    logic [SEG_W-1:0] seq_u;
    logic             seq_last;
    logic             in_acc;

    assign seq_u    = r_n - r_i;
    assign seq_last = (r_i == r_n);
    assign o_ready  = !r_busy || (pipe_en && seq_last);
    assign in_acc   = i_valid && o_ready;

    // zero segments act as one, anything above the bound is clamped
    always_comb begin
        if (r_seg_count == '0) begin
            n_seg = SEG_W'(1);
        end else if (r_seg_count > SEG_W'(MAX_SEGMENTS)) begin
            n_seg = SEG_W'(MAX_SEGMENTS);
        end else begin
            n_seg = r_seg_count;
        end
    end

    always_comb begin
        n_pts.x[0] = to_biased(i_data.start_x, r_frame_w);
        n_pts.y[0] = to_biased(i_data.start_y, r_frame_h);
        n_pts.x[1] = to_biased(i_data.ctrl1_x, r_frame_w);
        n_pts.y[1] = to_biased(i_data.ctrl1_y, r_frame_h);
        n_pts.x[2] = to_biased(i_data.ctrl2_x, r_frame_w);
        n_pts.y[2] = to_biased(i_data.ctrl2_y, r_frame_h);
        n_pts.x[3] = to_biased(i_data.end_x,   r_frame_w);
        n_pts.y[3] = to_biased(i_data.end_y,   r_frame_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_acc) begin
            r_busy <= 1'b1;
        end else if (pipe_en && seq_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pts <= n_pts;
            r_n   <= n_seg;
            r_i   <= i_data.first_curve ? '0 : SEG_W'(1);
        end else if (r_busy && pipe_en) begin
            r_i   <= r_i + SEG_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: squares of u = n-i, i and n
    // ------------------------------------------------------------------
    logic               r1_valid;
    logic               r1_last;
    logic [2*SEG_W-1:0] r1_uu;
    logic [2*SEG_W-1:0] r1_ii;
    logic [2*SEG_W-1:0] r1_nn;
    logic [SEG_W-1:0]   r1_u;
    logic [SEG_W-1:0]   r1_i;
    logic [SEG_W-1:0]   r1_n;
    t_curve_pts         r1_pts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (pipe_en) begin
            r1_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r1_last <= seq_last;
            r1_uu   <= seq_u * seq_u;
            r1_ii   <= r_i * r_i;
            r1_nn   <= r_n * r_n;
            r1_u    <= seq_u;
            r1_i    <= r_i;
            r1_n    <= r_n;
            r1_pts  <= r_pts;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: Bernstein weights u^3, 3u^2i, 3ui^2, i^3 and divisor n^3.
    // The middle weights never exceed n^3, so they fit WGT_W bits.
    // ------------------------------------------------------------------
    logic                  r2_valid;
    logic                  r2_last;
    logic [3:0][WGT_W-1:0] r2_w;
    logic [WGT_W-1:0]      r2_d;
    t_curve_pts            r2_pts;
    logic [WGT_W-1:0]      m_uui;
    logic [WGT_W-1:0]      m_uii;

    assign m_uui = r1_uu * r1_i;
    assign m_uii = r1_ii * r1_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (pipe_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r2_last <= r1_last;
            r2_w[0] <= r1_uu * r1_u;
            r2_w[1] <= WGT_W'({m_uui, 1'b0} + {1'b0, m_uui});
            r2_w[2] <= WGT_W'({m_uii, 1'b0} + {1'b0, m_uii});
            r2_w[3] <= r1_ii * r1_i;
            r2_d    <= r1_nn * r1_n;
            r2_pts  <= r1_pts;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: weight times coordinate, eight WGT_W x PT_W products
    // ------------------------------------------------------------------
    logic                   r3_valid;
    logic                   r3_last;
    logic [3:0][PROD_W-1:0] r3_px;
    logic [3:0][PROD_W-1:0] r3_py;
    logic [WGT_W-1:0]       r3_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (pipe_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r3_last <= r2_last;
            r3_d    <= r2_d;
            for (int k = 0; k < 4; k++) begin
                r3_px[k] <= PROD_W'(r2_w[k]) * PROD_W'(r2_pts.x[k]);
                r3_py[k] <= PROD_W'(r2_w[k]) * PROD_W'(r2_pts.y[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 4-5: sum the products, adding floor(d/2) for round-half-up.
    // All terms are non-negative; the total stays below d * 2^PT_W.
    // ------------------------------------------------------------------
    logic              r4_valid;
    logic              r4_last;
    logic [PROD_W-1:0] r4_ax;
    logic [PROD_W-1:0] r4_bx;
    logic [PROD_W-1:0] r4_ay;
    logic [PROD_W-1:0] r4_by;
    logic [WGT_W-1:0]  r4_d;
    logic [PROD_W-1:0] half_d;

    assign half_d = PROD_W'(r3_d >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (pipe_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r4_last <= r3_last;
            r4_d    <= r3_d;
            r4_ax   <= r3_px[0] + r3_px[1];
            r4_bx   <= r3_px[2] + r3_px[3] + half_d;
            r4_ay   <= r3_py[0] + r3_py[1];
            r4_by   <= r3_py[2] + r3_py[3] + half_d;
        end
    end

    logic              r5_valid;
    logic              r5_last;
    logic [PROD_W-1:0] r5_nx;
    logic [PROD_W-1:0] r5_ny;
    logic [WGT_W-1:0]  r5_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (pipe_en) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r5_last <= r4_last;
            r5_d    <= r4_d;
            r5_nx   <= r4_ax + r4_bx;
            r5_ny   <= r4_ay + r4_by;
        end
    end

    // ------------------------------------------------------------------
    // Divider: floor(num / n^3), restoring, DIV_BITS quotient bits per stage.
    // The remainder starts as the top bits of num (already below d because the
    // quotient fits QUO_W bits); the low bits shift out of sh while quotient bits
    // shift in, so after the last stage sh holds the quotient.
    // ------------------------------------------------------------------
    function automatic logic [WGT_W+QUO_W-1:0] div_steps(logic [WGT_W-1:0] rem,
                                                         logic [QUO_W-1:0] sh,
                                                         logic [WGT_W-1:0] dvs);
        logic [WGT_W:0] t;
        for (int b = 0; b < DIV_BITS; b++) begin
            t = {rem, sh[QUO_W-1]};
            if (t >= {1'b0, dvs}) begin
                rem = WGT_W'(t - {1'b0, dvs});
                sh  = {sh[QUO_W-2:0], 1'b1};
            end else begin
                rem = t[WGT_W-1:0];
                sh  = {sh[QUO_W-2:0], 1'b0};
            end
        end
        return {rem, sh};
    endfunction

    logic             r_dv_valid [DIV_STAGES];
    logic             r_dv_last  [DIV_STAGES];
    logic [WGT_W-1:0] r_dv_d     [DIV_STAGES];
    logic [WGT_W-1:0] r_dv_rem_x [DIV_STAGES];
    logic [WGT_W-1:0] r_dv_rem_y [DIV_STAGES];
    logic [QUO_W-1:0] r_dv_sh_x  [DIV_STAGES];
    logic [QUO_W-1:0] r_dv_sh_y  [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        logic                   vld;
        logic                   lst;
        logic [WGT_W-1:0]       dvs;
        logic [WGT_W-1:0]       rem_x;
        logic [WGT_W-1:0]       rem_y;
        logic [QUO_W-1:0]       sh_x;
        logic [QUO_W-1:0]       sh_y;
        logic [WGT_W+QUO_W-1:0] step_x;
        logic [WGT_W+QUO_W-1:0] step_y;

        if (s == 0) begin : g_head
            assign vld   = r5_valid;
            assign lst   = r5_last;
            assign dvs   = r5_d;
            assign rem_x = r5_nx[PROD_W-1:QUO_W];
            assign rem_y = r5_ny[PROD_W-1:QUO_W];
            assign sh_x  = r5_nx[QUO_W-1:0];
            assign sh_y  = r5_ny[QUO_W-1:0];
        end else begin : g_body
            assign vld   = r_dv_valid[s-1];
            assign lst   = r_dv_last[s-1];
            assign dvs   = r_dv_d[s-1];
            assign rem_x = r_dv_rem_x[s-1];
            assign rem_y = r_dv_rem_y[s-1];
            assign sh_x  = r_dv_sh_x[s-1];
            assign sh_y  = r_dv_sh_y[s-1];
        end

        assign step_x = div_steps(rem_x, sh_x, dvs);
        assign step_y = div_steps(rem_y, sh_y, dvs);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[s] <= 1'b0;
            end else if (pipe_en) begin
                r_dv_valid[s] <= vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r_dv_last[s]  <= lst;
                r_dv_d[s]     <= dvs;
                r_dv_rem_x[s] <= step_x[WGT_W+QUO_W-1:QUO_W];
                r_dv_rem_y[s] <= step_y[WGT_W+QUO_W-1:QUO_W];
                r_dv_sh_x[s]  <= step_x[QUO_W-1:0];
                r_dv_sh_y[s]  <= step_y[QUO_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: remove the bias and saturate. The biased quotient is never
    // negative, so only the upper bound can be hit.
    // ------------------------------------------------------------------
    function automatic logic [COORD_W-1:0] unbias_sat(logic [QUO_W-1:0] q);
        if (q[QUO_W-1:COORD_W] != '0) begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
        return {~q[COORD_W-1], q[COORD_W-2:0]};
    endfunction

    t_point_item r_out;
    t_point_item n_out;

    always_comb begin
        n_out.point_x    = unbias_sat(r_dv_sh_x[DIV_STAGES-1]);
        n_out.point_y    = unbias_sat(r_dv_sh_y[DIV_STAGES-1]);
        n_out.last_point = r_dv_last[DIV_STAGES-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_out_valid <= r_dv_valid[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== rtl/cbf_checker.sv =====
`include "cubic_bezier_flattener_unit_macros.svh"

module cbf_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           o_ready,
    input  cbf_pkg::t_curve_item           i_data,
    input  logic                           o_valid,
    input  logic                           i_ready,
    input  cbf_pkg::t_point_item           o_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cbf_pkg::ADDR_W-1:0]     paddr,
    input  logic [cbf_pkg::APB_DW-1:0]     pwdata,
    input  logic [cbf_pkg::APB_DW-1:0]     prdata,
    input  logic                           pready
);
    import cbf_pkg::*;

    // a waiting curve stays put
    `CBF_ASSERT_NXT(a_in_hold, i_valid && !o_ready, i_valid && $stable(i_data),
                    "curve transaction dropped or changed while waiting")

    // a stalled point stays put
    `CBF_ASSERT_NXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_data),
                    "point dropped or changed while stalled")

    // reset leaves no point pending
    `CBF_ASSERT_RST(a_reset_empty, !o_valid, "output valid right after reset")

    // segment count reads back what was just written
    `CBF_ASSERT_IMP(a_seg_readback,
                    $past(i_rst_n) && $past(psel && penable && pwrite && pready)
                    && ($past(paddr[ADDR_W-1:2]) == REG_SEG_COUNT) && psel && !pwrite
                    && (paddr[ADDR_W-1:2] == REG_SEG_COUNT),
                    prdata == APB_DW'($past(pwdata[SEG_W-1:0])),
                    "segment count readback mismatch")

endmodule

bind cubic_bezier_flattener_unit cbf_checker u_cbf_checker (.*);
